>>> rtl/lbps_pkg.sv
// lbps_pkg: shared widths and types for the literal byte pattern search unit
// no dependencies; used by lbps_cell, lbps_widen and the top level
package lbps_pkg;

  localparam int BYTE_W     = 8;
  localparam int OFF_W      = 32;
  localparam int CTX_W      = 16;
  localparam int PLEN_W     = 5;
  localparam int LIT_BYTES  = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  // register indexes of the write port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_LOW    = 3'd1,
    REG_PATTERN_HIGH   = 3'd2,
    REG_REPORT_ALL     = 3'd3,
    REG_CTX_BEFORE     = 3'd4,
    REG_CTX_AFTER      = 3'd5,
    REG_FILE_SIZE      = 3'd6
  } cfg_reg_t;

  // compare setup handed to one window cell
  typedef struct packed {
    logic              en;
    logic [BYTE_W-1:0] lit;
  } cell_cmp_t;

endpackage

>>> rtl/lbps_cell.sv
// lbps_cell: one window byte of the search chain, shifts to its neighbor and
// compares the incoming byte against its literal byte; uses lbps_pkg
module lbps_cell (
  input  logic                         clk,
  input  logic                         shift_en,
  input  logic [lbps_pkg::BYTE_W-1:0]  byte_in,
  input  lbps_pkg::cell_cmp_t          cmp,
  output logic [lbps_pkg::BYTE_W-1:0]  byte_out,
  output logic                         match
);

  logic [lbps_pkg::BYTE_W-1:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  // compare uses the byte this cell takes on the current shift
  assign match    = !cmp.en || (byte_in == cmp.lit);
  assign byte_out = byte_r;

endmodule

>>> rtl/lbps_widen.sv
// lbps_widen: pipeline that widens a hit by the context bytes and clips it,
// with the output register; uses lbps_pkg
module lbps_widen #(
  parameter int LEN_W = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [lbps_pkg::OFF_W-1:0]    req_off,
  input  logic [LEN_W-1:0]              req_len,
  input  logic [lbps_pkg::CTX_W-1:0]    ctx_before,
  input  logic [lbps_pkg::CTX_W-1:0]    ctx_after,
  input  logic [lbps_pkg::OFF_W-1:0]    file_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lbps_pkg::OFF_W-1:0]    out_hit_offset,
  output logic [lbps_pkg::OFF_W-1:0]    out_hit_length
);

  localparam int W = lbps_pkg::OFF_W;

  logic         s1_v_r, s2_v_r, s3_v_r, o_v_r;
  logic         adv1, adv2, adv3, adv_o;

  logic [W-1:0]     s1_off_r;
  logic [LEN_W-1:0] s1_len_r;

  logic [W-1:0] s2_mstart_r, s2_room_r;
  logic [W:0]   s2_mend_r;
  logic         s2_room_ok_r;

  logic [W-1:0] s3_xstart_r;
  logic [W:0]   s3_xend_r;

  logic [W-1:0] o_off_r, o_len_r;

  logic [W-1:0] lm1, mstart_nxt, room_nxt;
  logic [W:0]   mend_nxt, fs_ext;
  logic         room_ok_nxt;
  logic [W-1:0] pre_ctx, add, cb_ext, ca_ext, xstart_nxt;
  logic [W:0]   xend_nxt, diff;
  logic [W-1:0] len_nxt;

  // stall chain: a stage moves when it is empty or the next one moves
  assign adv_o     = !o_v_r || !out_stall;
  assign adv3      = !s3_v_r || adv_o;
  assign adv2      = !s2_v_r || adv3;
  assign adv1      = !s1_v_r || adv2;
  assign req_ready = adv1;

  // match bounds
  always_comb begin
    lm1         = W'(s1_len_r) - W'(1);
    mstart_nxt  = (s1_off_r >= lm1) ? (s1_off_r - lm1) : '0;
    mend_nxt    = {1'b0, s1_off_r} + (W+1)'(1);
    fs_ext      = {1'b0, file_size};
    room_ok_nxt = fs_ext > mend_nxt;
    room_nxt    = W'(fs_ext - mend_nxt);
  end

  // context clipped at offset zero and at the file end
  always_comb begin
    cb_ext     = W'(ctx_before);
    ca_ext     = W'(ctx_after);
    pre_ctx    = (cb_ext < s2_mstart_r) ? cb_ext : s2_mstart_r;
    xstart_nxt = s2_mstart_r - pre_ctx;
    if (s2_room_ok_r) begin
      add = (ca_ext < s2_room_r) ? ca_ext : s2_room_r;
    end else begin
      add = '0;
    end
    xend_nxt = s2_mend_r + {1'b0, add};
  end

  // length saturates at the top of the 32-bit range
  always_comb begin
    diff    = s3_xend_r - {1'b0, s3_xstart_r};
    len_nxt = diff[W] ? '1 : diff[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (adv1) begin
        s1_v_r <= req_valid;
      end
      if (adv2) begin
        s2_v_r <= s1_v_r;
      end
      if (adv3) begin
        s3_v_r <= s2_v_r;
      end
      if (adv_o) begin
        o_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_off_r <= req_off;
      s1_len_r <= req_len;
    end
    if (adv2) begin
      s2_mstart_r  <= mstart_nxt;
      s2_mend_r    <= mend_nxt;
      s2_room_ok_r <= room_ok_nxt;
      s2_room_r    <= room_nxt;
    end
    if (adv3) begin
      s3_xstart_r <= xstart_nxt;
      s3_xend_r   <= xend_nxt;
    end
    if (adv_o) begin
      o_off_r <= s3_xstart_r;
      o_len_r <= len_nxt;
    end
  end

  assign out_valid      = o_v_r;
  assign out_hit_offset = o_off_r;
  assign out_hit_length = o_len_r;

endmodule

>>> rtl/literal_byte_pattern_search_unit.sv
// literal_byte_pattern_search_unit: streaming literal substring search, top level
// depends on lbps_pkg, lbps_cell (window chain) and lbps_widen (hit widening)
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_data_byte, in_byte_offset, in_range_last
//   out      output     out_valid/out_stall  out_hit_offset, out_hit_length
//   cfg      input      cfg_wr_en            cfg_index, cfg_wdata
//
// one byte per cycle sustained while in_stall is low; the window chain shifts
// and compares every byte in the cycle it is accepted
// a hit reaches out_valid through the three-stage widening pipeline (s1, s2,
// s3) and then the output register; out_stall can hold it in any of them
// reset is synchronous on rst_n low: matcher state, pipeline valids and
// the registers return to their defaults (length 1, report all hits)
// in_stall rises only when the widening pipeline is full and the output
// request is held by out_stall; bytes without a hit still need a free slot
module literal_byte_pattern_search_unit #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input requests
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lbps_pkg::BYTE_W-1:0]         in_data_byte,
  input  logic [lbps_pkg::OFF_W-1:0]          in_byte_offset,
  input  logic                                in_range_last,
  // result requests
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lbps_pkg::OFF_W-1:0]          out_hit_offset,
  output logic [lbps_pkg::OFF_W-1:0]          out_hit_length,
  // register writes
  input  logic                                cfg_wr_en,
  input  logic [lbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lbps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int LW = $clog2(MAX_PATTERN + 1);

  // configuration registers
  logic [lbps_pkg::PLEN_W-1:0]     pat_len_r;
  logic [lbps_pkg::CFG_DATA_W-1:0] pat_lo_r, pat_hi_r;
  logic                            report_all_r;
  logic [lbps_pkg::CTX_W-1:0]      ctx_before_r, ctx_after_r;
  logic [lbps_pkg::OFF_W-1:0]      file_size_r;

  // matcher state
  logic [LW-1:0] seen_r, guard_r, seen_nxt, guard_nxt;
  logic          first_r, first_nxt;

  logic [LW-1:0] len_eff;
  logic          in_acc, widen_ready, cand, hit_now;
  logic [2*lbps_pkg::CFG_DATA_W-1:0] pat_vec;

  lbps_pkg::cell_cmp_t             cmp   [MAX_PATTERN];
  logic [lbps_pkg::BYTE_W-1:0]     win   [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]          match;

  assign in_stall = !widen_ready;
  assign in_acc   = in_valid && !in_stall;

  // register writes; the user writes only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r    <= lbps_pkg::PLEN_W'(1);
      pat_lo_r     <= '0;
      pat_hi_r     <= '0;
      report_all_r <= 1'b1;
      ctx_before_r <= '0;
      ctx_after_r  <= '0;
      file_size_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lbps_pkg::REG_PATTERN_LENGTH: pat_len_r    <= cfg_wdata[lbps_pkg::PLEN_W-1:0];
        lbps_pkg::REG_PATTERN_LOW:    pat_lo_r     <= cfg_wdata;
        lbps_pkg::REG_PATTERN_HIGH:   pat_hi_r     <= cfg_wdata;
        lbps_pkg::REG_REPORT_ALL:     report_all_r <= cfg_wdata[0];
        lbps_pkg::REG_CTX_BEFORE:     ctx_before_r <= cfg_wdata[lbps_pkg::CTX_W-1:0];
        lbps_pkg::REG_CTX_AFTER:      ctx_after_r  <= cfg_wdata[lbps_pkg::CTX_W-1:0];
        lbps_pkg::REG_FILE_SIZE:      file_size_r  <= cfg_wdata[lbps_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // lengths above the window size clamp to the window size
  always_comb begin
    if (32'(pat_len_r) > MAX_PATTERN) begin
      len_eff = LW'(MAX_PATTERN);
    end else begin
      len_eff = LW'(pat_len_r);
    end
  end

  // cell j holds the byte j places back and checks it against literal
  // byte len-1-j; literal bytes past the two words read as zero
  assign pat_vec = {pat_hi_r, pat_lo_r};

  always_comb begin
    int k;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      k          = int'(len_eff) - 1 - j;
      cmp[j].en  = (k >= 0);
      if (k >= 0 && k < lbps_pkg::LIT_BYTES) begin
        cmp[j].lit = pat_vec[{k[3:0], 3'b000} +: lbps_pkg::BYTE_W];
      end else begin
        cmp[j].lit = '0;
      end
    end
  end

  // window chain: newest byte enters cell 0 and moves one cell per request
  // stale cells from an earlier range are masked by the bytes-seen count
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [lbps_pkg::BYTE_W-1:0] byte_in;
    if (j == 0) begin : g_head
      assign byte_in = in_data_byte;
    end else begin : g_tail
      assign byte_in = win[j-1];
    end
    lbps_cell u_cell (
      .clk      (clk),
      .shift_en (in_acc),
      .byte_in  (byte_in),
      .cmp      (cmp[j]),
      .byte_out (win[j]),
      .match    (match[j])
    );
  end

  // hit decision and matcher state update
  always_comb begin
    seen_nxt  = (seen_r < LW'(MAX_PATTERN)) ? seen_r + LW'(1) : seen_r;
    cand      = (guard_r == '0) && (len_eff != '0) && (seen_nxt >= len_eff) &&
                (report_all_r || !first_r);
    hit_now   = cand && (&match);
    guard_nxt = guard_r;
    first_nxt = first_r;
    if (guard_r != '0) begin
      guard_nxt = guard_r - LW'(1);
    end else if (hit_now) begin
      // ends inside the next len-1 bytes would overlap this hit
      guard_nxt = len_eff - LW'(1);
      first_nxt = 1'b1;
    end
    if (in_range_last) begin
      seen_nxt  = '0;
      guard_nxt = '0;
      first_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      guard_r <= '0;
      first_r <= 1'b0;
    end else if (in_acc) begin
      seen_r  <= seen_nxt;
      guard_r <= guard_nxt;
      first_r <= first_nxt;
    end
  end

  // widening pipeline and output register
  lbps_widen #(
    .LEN_W (LW)
  ) u_widen (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (in_acc && hit_now),
    .req_ready      (widen_ready),
    .req_off        (in_byte_offset),
    .req_len        (len_eff),
    .ctx_before     (ctx_before_r),
    .ctx_after      (ctx_after_r),
    .file_size      (file_size_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit_offset (out_hit_offset),
    .out_hit_length (out_hit_length)
  );

`ifndef SYNTHESIS
  // no hit may end while an earlier hit still covers the byte
  a_guard_blocks_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && guard_r != '0) |-> !hit_now)
    else $error("hit reported inside a previous match");

  // a hit arms the guard with len-1 unless the range ends on it
  a_guard_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && hit_now && !in_range_last) |=> (guard_r == $past(len_eff) - LW'(1)))
    else $error("overlap guard not armed after hit");

  // the last byte of a range leaves the matcher cleared
  a_range_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_range_last) |=> (seen_r == '0 && guard_r == '0 && !first_r))
    else $error("matcher not cleared at end of range");

  // a widened match always covers at least the matched byte
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit_length != '0))
    else $error("zero-length hit");
`endif

endmodule
